/* src/grtw_pkg.sv */
// Shared types and constants for the grid ray trace to wall block.
`default_nettype none

package grtw_pkg;

    // Default configuration
    localparam int MAP_SIZE_DEF    = 256;
    localparam int LAYER_COUNT_DEF = 8;
    localparam int MAX_STEPS_DEF   = 16;
    localparam int QUEUE_DEPTH     = 2;

    // Fixed geometry of the fields
    localparam int CELL_ONE  = 256;
    localparam int COORD_W   = 16;
    localparam int CELL_W    = 8;
    localparam int LAYER_W   = 3;
    localparam int DIST0_W   = 24;
    localparam int MAP_ROW_W = LAYER_W + CELL_W;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TRACE = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [CELL_W-1:0]     cell_x;
        logic [CELL_W-1:0]     cell_y;
        logic [LAYER_W-1:0]    layer;
        logic                  is_wall;
        logic [COORD_W-1:0]    start_x;
        logic [COORD_W-1:0]    start_y;
        logic [COORD_W-1:0]    end_x;
        logic [COORD_W-1:0]    end_y;
    } in_item_t;

    typedef struct packed {
        logic                  hit;
        logic [COORD_W-1:0]    point_x;
        logic [COORD_W-1:0]    point_y;
        logic                  degenerate;
    } out_item_t;

    typedef enum logic [1:0] {
        JOB_WRITE,
        JOB_TRACE,
        JOB_DEGEN
    } job_kind_t;

    // Classified work passed from front to back
    typedef struct packed {
        job_kind_t             kind;
        logic [CELL_W-1:0]     cell_x;
        logic [CELL_W-1:0]     cell_y;
        logic [LAYER_W-1:0]    layer;
        logic                  is_wall;
        logic [COORD_W-1:0]    start_x;
        logic [COORD_W-1:0]    start_y;
        logic [CELL_W-1:0]     end_cx;
        logic [CELL_W-1:0]     end_cy;
        logic [COORD_W-1:0]    adx;
        logic [COORD_W-1:0]    ady;
        logic                  dx_neg;
        logic                  dy_neg;
        logic [DIST0_W-1:0]    cross_x;
        logic [DIST0_W-1:0]    cross_y;
    } job_t;

    // Map port request from back to map
    typedef struct packed {
        logic                  wr_en;
        logic                  rd_en;
        logic                  wall;
        logic [MAP_ROW_W-1:0]  row;
        logic [CELL_W-1:0]     col;
    } map_req_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_STEP,
        B_CHECK,
        B_MUL,
        B_DSTART,
        B_DIV,
        B_ADD,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

/* src/grtw_front.sv */
// Front end: classifies an incoming transaction and precomputes the trace setup.
`default_nettype none

module grtw_front #(
    parameter int MAP_SIZE    = grtw_pkg::MAP_SIZE_DEF,
    parameter int LAYER_COUNT = grtw_pkg::LAYER_COUNT_DEF
) (
    input  grtw_pkg::in_item_t item,
    output grtw_pkg::job_t     job,
    output logic               keep
);

    logic signed [grtw_pkg::COORD_W:0] dx;
    logic signed [grtw_pkg::COORD_W:0] dy;
    logic [grtw_pkg::COORD_W-1:0]      adx;
    logic [grtw_pkg::COORD_W-1:0]      ady;
    logic [grtw_pkg::CELL_W:0]         nx0;
    logic [grtw_pkg::CELL_W:0]         ny0;
    logic [grtw_pkg::CELL_W+grtw_pkg::COORD_W:0] px;
    logic [grtw_pkg::CELL_W+grtw_pkg::COORD_W:0] py;
    logic                              in_map;
    logic [grtw_pkg::LAYER_W-1:0]      layer_c;

    // Direction and its magnitude
    always_comb
    begin
        dx  = $signed({1'b0, item.end_x}) - $signed({1'b0, item.start_x});
        dy  = $signed({1'b0, item.end_y}) - $signed({1'b0, item.start_y});
        adx = dx[grtw_pkg::COORD_W] ? grtw_pkg::COORD_W'(-dx) : dx[grtw_pkg::COORD_W-1:0];
        ady = dy[grtw_pkg::COORD_W] ? grtw_pkg::COORD_W'(-dy) : dy[grtw_pkg::COORD_W-1:0];
    end

    // Distance to first boundary, cross multiplied by the other axis
    always_comb
    begin
        nx0 = dx[grtw_pkg::COORD_W] ? {1'b0, item.start_x[7:0]}
                                    : 9'(grtw_pkg::CELL_ONE) - {1'b0, item.start_x[7:0]};
        ny0 = dy[grtw_pkg::COORD_W] ? {1'b0, item.start_y[7:0]}
                                    : 9'(grtw_pkg::CELL_ONE) - {1'b0, item.start_y[7:0]};
        px  = nx0 * ady;
        py  = ny0 * adx;
    end

    // Range check for writes, clamp of the trace layer
    always_comb
    begin
        in_map  = (int'(item.cell_x) < MAP_SIZE) && (int'(item.cell_y) < MAP_SIZE)
               && (int'(item.layer) < LAYER_COUNT);
        layer_c = (int'(item.layer) > LAYER_COUNT - 1) ? grtw_pkg::LAYER_W'(LAYER_COUNT - 1)
                                                        : item.layer;
    end

    // Build the job
    always_comb
    begin
        job.cell_x  = item.cell_x;
        job.cell_y  = item.cell_y;
        job.is_wall = item.is_wall;
        job.start_x = item.start_x;
        job.start_y = item.start_y;
        job.end_cx  = item.end_x[15:8];
        job.end_cy  = item.end_y[15:8];
        job.adx     = adx;
        job.ady     = ady;
        job.dx_neg  = dx[grtw_pkg::COORD_W];
        job.dy_neg  = dy[grtw_pkg::COORD_W];
        job.cross_x = px[grtw_pkg::DIST0_W-1:0];
        job.cross_y = py[grtw_pkg::DIST0_W-1:0];
        if (item.cmd == grtw_pkg::CMD_WRITE)
        begin
            job.kind  = grtw_pkg::JOB_WRITE;
            job.layer = item.layer;
            keep      = in_map;
        end
        else
        begin
            job.kind  = ((adx == '0) && (ady == '0)) ? grtw_pkg::JOB_DEGEN : grtw_pkg::JOB_TRACE;
            job.layer = layer_c;
            keep      = 1'b1;
        end
    end

endmodule

`default_nettype wire

/* src/grtw_fifo.sv */
// Short job queue between the front and the back.
`default_nettype none

module grtw_fifo #(
    parameter int DEPTH = grtw_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  grtw_pkg::job_t  wr_data,
    input  logic            rd,
    output grtw_pkg::job_t  rd_data,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    grtw_pkg::job_t     store_reg [DEPTH];
    logic [PTR_W-1:0]   wptr_reg;
    logic [PTR_W-1:0]   rptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_wr;
    logic               do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = store_reg[rptr_reg];
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (do_rd)
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        if (do_wr)
            store_reg[wptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

/* src/grtw_map.sv */
// Wall bit map memory, one row of cells per word, with a clearing pass after reset.
`default_nettype none

module grtw_map #(
    parameter int MAP_SIZE    = grtw_pkg::MAP_SIZE_DEF,
    parameter int LAYER_COUNT = grtw_pkg::LAYER_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  grtw_pkg::map_req_t  req,
    output logic                rd_bit,
    output logic                busy
);

    localparam int ROWS  = MAP_SIZE * LAYER_COUNT;
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(MAP_SIZE);

    logic [MAP_SIZE-1:0] mem [ROWS];
    logic [MAP_SIZE-1:0] rd_row_reg;
    logic [COL_W-1:0]    rd_col_reg;
    logic [ROW_W-1:0]    clr_row_reg;
    logic                busy_reg;

    assign busy   = busy_reg;
    assign rd_bit = rd_row_reg[rd_col_reg];

    // Sweep every row once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_row_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_row_reg <= clr_row_reg + 1'b1;
            if (clr_row_reg == ROW_W'(ROWS - 1))
                busy_reg <= 1'b0;
        end
    end

    // Write one cell or clear one row; registered row read
    always_ff @(posedge clk)
    begin
        if (busy_reg)
            mem[clr_row_reg] <= '0;
        else if (req.wr_en)
            mem[req.row[ROW_W-1:0]][req.col[COL_W-1:0]] <= req.wall;
        if (req.rd_en)
        begin
            rd_row_reg <= mem[req.row[ROW_W-1:0]];
            rd_col_reg <= req.col[COL_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* src/grtw_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module grtw_div #(
    parameter int N = 37,
    parameter int D = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [N-1:0]  dividend,
    input  logic [D-1:0]  divisor,
    output logic          done,
    output logic [N-1:0]  quotient
);

    localparam int CNT_W = $clog2(N + 1);

    logic [N-1:0]     num_reg;
    logic [D-1:0]     den_reg;
    logic [D-1:0]     rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [D:0]       trial;
    logic             ge;

    assign trial    = {rem_reg, num_reg[N-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign done     = done_reg;
    assign quotient = num_reg;

    // Control: count the bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift in one quotient bit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? D'(trial - {1'b0, den_reg}) : trial[D-1:0];
            num_reg <= {num_reg[N-2:0], ge};
        end
    end

endmodule

`default_nettype wire

/* src/grtw_back.sv */
// Back end: runs map writes and DDA traces, computes the hit point, holds the result.
`default_nettype none

module grtw_back #(
    parameter int MAP_SIZE    = grtw_pkg::MAP_SIZE_DEF,
    parameter int LAYER_COUNT = grtw_pkg::LAYER_COUNT_DEF,
    parameter int MAX_STEPS   = grtw_pkg::MAX_STEPS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  grtw_pkg::job_t       job,
    input  logic                 q_empty,
    output logic                 q_pop,
    output grtw_pkg::map_req_t   map_req,
    input  logic                 rd_bit,
    input  logic                 pop,
    output logic                 empty,
    output grtw_pkg::out_item_t  result
);

    localparam int CW     = grtw_pkg::COORD_W;
    localparam int CUR_W  = $clog2(grtw_pkg::CELL_ONE + MAX_STEPS + 1) + 1;
    localparam int PROD_W = $clog2(grtw_pkg::CELL_ONE * (MAX_STEPS + 1) + 1) + CW;
    localparam int OFF_W  = CUR_W + 9;
    localparam int MAG_W  = OFF_W + CW;
    localparam int DIVN_W = MAG_W + 2;
    localparam int DIVD_W = CW + 1;
    localparam int CNT_W  = $clog2(MAX_STEPS + 1);
    localparam int SUM_W  = DIVN_W + 2;

    grtw_pkg::back_state_t state_reg, state_next;

    // Trace context
    logic [grtw_pkg::LAYER_W-1:0] layer_reg;
    logic [CW-1:0]                sx_reg, sy_reg, adx_reg, ady_reg;
    logic [grtw_pkg::CELL_W-1:0]  ecx_reg, ecy_reg;
    logic                         dxn_reg, dyn_reg;
    logic [PROD_W-1:0]            crx_reg, cry_reg;
    logic signed [CUR_W-1:0]      curx_reg, cury_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         xstep_reg;
    // Hit point
    logic [MAG_W-1:0]             mag_reg;
    logic                         neg_reg;
    logic [CW-1:0]                pmain_reg;
    grtw_pkg::out_item_t          res_reg;
    grtw_pkg::out_item_t          out_reg;
    logic                         out_valid_reg;

    logic                         xs;
    logic signed [CUR_W-1:0]      nx_cur, ny_cur;
    logic signed [CUR_W-1:0]      b_cell;
    logic signed [OFF_W-1:0]      b_val, off;
    logic [OFF_W-1:0]             off_abs;
    logic                         m_neg, o_neg;
    logic [CW-1:0]                s_main, ad_main, ad_other;
    logic [MAG_W-1:0]             mag;
    logic [DIVN_W-1:0]            div_n;
    logic [DIVD_W-1:0]            div_d;
    logic                         div_start, div_done;
    logic [DIVN_W-1:0]            quot;
    logic signed [SUM_W-1:0]      p_other;
    logic [CW-1:0]                p_other_sat;
    logic                         at_end, out_load;

    function automatic logic [grtw_pkg::CELL_W-1:0] clamp_cell(input logic signed [CUR_W-1:0] v);
        logic [grtw_pkg::CELL_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed(CUR_W'(MAP_SIZE - 1)))
            r = grtw_pkg::CELL_W'(MAP_SIZE - 1);
        else
            r = v[grtw_pkg::CELL_W-1:0];
        return r;
    endfunction

    function automatic logic [grtw_pkg::MAP_ROW_W-1:0] row_of(
        input logic [grtw_pkg::LAYER_W-1:0] l, input logic [grtw_pkg::CELL_W-1:0] y);
        return grtw_pkg::MAP_ROW_W'(int'(l) * MAP_SIZE + int'(y));
    endfunction

    // Step choice by cross product compare, and the next cell
    always_comb
    begin
        xs     = crx_reg < cry_reg;
        nx_cur = curx_reg;
        ny_cur = cury_reg;
        if (xs)
            nx_cur = dxn_reg ? curx_reg - 1'b1 : curx_reg + 1'b1;
        else
            ny_cur = dyn_reg ? cury_reg - 1'b1 : cury_reg + 1'b1;
    end

    assign at_end = (curx_reg == $signed({{(CUR_W-8){1'b0}}, ecx_reg}))
                 && (cury_reg == $signed({{(CUR_W-8){1'b0}}, ecy_reg}));

    // Boundary point on the stepped axis and the product for the other axis
    always_comb
    begin
        b_cell   = xstep_reg ? curx_reg : cury_reg;
        m_neg    = xstep_reg ? dxn_reg : dyn_reg;
        o_neg    = xstep_reg ? dyn_reg : dxn_reg;
        s_main   = xstep_reg ? sx_reg : sy_reg;
        ad_main  = xstep_reg ? adx_reg : ady_reg;
        ad_other = xstep_reg ? ady_reg : adx_reg;
        b_val    = (OFF_W'(b_cell) + OFF_W'(m_neg)) <<< 8;
        off      = b_val - $signed({{(OFF_W-CW){1'b0}}, s_main});
        off_abs  = off[OFF_W-1] ? OFF_W'(-off) : off;
        mag      = off_abs * ad_other;
        div_n    = {mag_reg, 1'b0} + DIVN_W'(ad_main);
        div_d    = {ad_main, 1'b0};
    end

    // Other coordinate: start plus signed rounded quotient, saturated
    always_comb
    begin
        p_other = $signed(SUM_W'(xstep_reg ? sy_reg : sx_reg));
        if (neg_reg)
            p_other = p_other - $signed(SUM_W'(quot));
        else
            p_other = p_other + $signed(SUM_W'(quot));
        if (p_other < 0)
            p_other_sat = '0;
        else if (p_other > $signed(SUM_W'(16'hFFFF)))
            p_other_sat = '1;
        else
            p_other_sat = p_other[CW-1:0];
    end

    grtw_div #(.N(DIVN_W), .D(DIVD_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (quot)
    );

    assign out_load = (state_reg == grtw_pkg::B_DONE) && (!out_valid_reg || pop);
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    // Next state and handshakes
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        map_req    = '0;
        case (state_reg)
            grtw_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (job.kind)
                        grtw_pkg::JOB_WRITE:
                        begin
                            map_req.wr_en = 1'b1;
                            map_req.wall  = job.is_wall;
                            map_req.row   = row_of(job.layer, job.cell_y);
                            map_req.col   = job.cell_x;
                        end
                        grtw_pkg::JOB_TRACE: state_next = grtw_pkg::B_STEP;
                        grtw_pkg::JOB_DEGEN: state_next = grtw_pkg::B_DONE;
                        default:             state_next = grtw_pkg::B_IDLE;
                    endcase
                end
            end
            grtw_pkg::B_STEP:
            begin
                map_req.rd_en = 1'b1;
                map_req.row   = row_of(layer_reg, clamp_cell(ny_cur));
                map_req.col   = clamp_cell(nx_cur);
                state_next    = grtw_pkg::B_CHECK;
            end
            grtw_pkg::B_CHECK:
            begin
                if (rd_bit)
                    state_next = grtw_pkg::B_MUL;
                else if (at_end || cnt_reg == CNT_W'(MAX_STEPS))
                    state_next = grtw_pkg::B_DONE;
                else
                    state_next = grtw_pkg::B_STEP;
            end
            grtw_pkg::B_MUL:    state_next = grtw_pkg::B_DSTART;
            grtw_pkg::B_DSTART:
            begin
                div_start  = 1'b1;
                state_next = grtw_pkg::B_DIV;
            end
            grtw_pkg::B_DIV:
            begin
                if (div_done)
                    state_next = grtw_pkg::B_ADD;
            end
            grtw_pkg::B_ADD:    state_next = grtw_pkg::B_DONE;
            grtw_pkg::B_DONE:
            begin
                if (out_load)
                    state_next = grtw_pkg::B_IDLE;
            end
            default:            state_next = grtw_pkg::B_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= grtw_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // Trace datapath
    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= res_reg;
        case (state_reg)
            grtw_pkg::B_IDLE:
            begin
                res_reg   <= '{hit: 1'b0, point_x: '0, point_y: '0,
                               degenerate: (job.kind == grtw_pkg::JOB_DEGEN)};
                layer_reg <= job.layer;
                sx_reg    <= job.start_x;
                sy_reg    <= job.start_y;
                adx_reg   <= job.adx;
                ady_reg   <= job.ady;
                ecx_reg   <= job.end_cx;
                ecy_reg   <= job.end_cy;
                dxn_reg   <= job.dx_neg;
                dyn_reg   <= job.dy_neg;
                crx_reg   <= PROD_W'(job.cross_x);
                cry_reg   <= PROD_W'(job.cross_y);
                curx_reg  <= $signed({{(CUR_W-8){1'b0}}, job.start_x[15:8]});
                cury_reg  <= $signed({{(CUR_W-8){1'b0}}, job.start_y[15:8]});
                cnt_reg   <= '0;
            end
            grtw_pkg::B_STEP:
            begin
                xstep_reg <= xs;
                curx_reg  <= nx_cur;
                cury_reg  <= ny_cur;
                cnt_reg   <= cnt_reg + 1'b1;
                if (xs)
                    crx_reg <= crx_reg + PROD_W'({ady_reg, 8'h00});
                else
                    cry_reg <= cry_reg + PROD_W'({adx_reg, 8'h00});
            end
            grtw_pkg::B_MUL:
            begin
                mag_reg <= mag;
                neg_reg <= off[OFF_W-1] ^ o_neg ^ m_neg;
                if (b_val < 0)
                    pmain_reg <= '0;
                else if (b_val > $signed(OFF_W'(16'hFFFF)))
                    pmain_reg <= '1;
                else
                    pmain_reg <= b_val[CW-1:0];
            end
            grtw_pkg::B_ADD:
            begin
                res_reg.hit     <= 1'b1;
                res_reg.point_x <= xstep_reg ? pmain_reg : p_other_sat;
                res_reg.point_y <= xstep_reg ? p_other_sat : pmain_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/grid_ray_trace_to_wall_core.sv */
// Top level of the grid ray trace to wall block.
//
// Keeps one wall bit per cell on LAYER_COUNT layers of MAP_SIZE x MAP_SIZE
// cells and traces Q8.8 segments through it by DDA cell stepping. A write
// transaction (cmd 0) updates one cell and gives no result; a trace (cmd 1)
// gives exactly one result. After reset the map is swept clear one row per
// cycle, all MAP_SIZE*LAYER_COUNT rows (2048 by default), with full held
// high. Classified transactions wait in a two-entry queue. In the back end
// a write is one map write; each DDA step of a trace is a row read of the
// map memory and the bit test, for up to MAX_STEPS steps without a hit; a
// hit adds the boundary multiply and a one-bit-per-cycle divider. A
// zero-length segment goes straight to the result.
`default_nettype none

module grid_ray_trace_to_wall_core #(
    parameter int MAP_SIZE    = grtw_pkg::MAP_SIZE_DEF,
    parameter int LAYER_COUNT = grtw_pkg::LAYER_COUNT_DEF,
    parameter int MAX_STEPS   = grtw_pkg::MAX_STEPS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  grtw_pkg::in_item_t   item,
    output logic                 empty,
    input  logic                 pop,
    output grtw_pkg::out_item_t  result
);

    grtw_pkg::job_t     job_in, job_head;
    grtw_pkg::map_req_t map_req;
    logic               keep, q_full, q_empty, q_pop, map_busy, rd_bit;

    // Hold off transactions while the queue is full or the map is clearing
    assign full = q_full || map_busy;

    grtw_front #(.MAP_SIZE(MAP_SIZE), .LAYER_COUNT(LAYER_COUNT)) u_front (
        .item (item),
        .job  (job_in),
        .keep (keep)
    );

    grtw_fifo #(.DEPTH(grtw_pkg::QUEUE_DEPTH)) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (push && !full && keep),
        .wr_data (job_in),
        .rd      (q_pop),
        .rd_data (job_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    grtw_map #(.MAP_SIZE(MAP_SIZE), .LAYER_COUNT(LAYER_COUNT)) u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (map_req),
        .rd_bit (rd_bit),
        .busy   (map_busy)
    );

    grtw_back #(
        .MAP_SIZE    (MAP_SIZE),
        .LAYER_COUNT (LAYER_COUNT),
        .MAX_STEPS   (MAX_STEPS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .job     (job_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .map_req (map_req),
        .rd_bit  (rd_bit),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

`default_nettype wire

/* src/grtw_checker.sv */
// Port checker for the grid ray trace to wall block, bound to the top level.
`default_nettype none

module grtw_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input grtw_pkg::in_item_t  item,
    input logic                empty,
    input logic                pop,
    input grtw_pkg::out_item_t result
);

    // Hold a waiting result until it is taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while waiting");

    // A zero-length segment reports no hit and a zero point
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.degenerate) |->
        (!result.hit && result.point_x == '0 && result.point_y == '0))
        else $error("degenerate result carries a hit");

    // No hit means a zero point
    a_nohit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.hit) |-> (result.point_x == '0 && result.point_y == '0))
        else $error("miss result carries a point");

    // A hit is never flagged degenerate
    a_hitdeg: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.hit) |-> !result.degenerate)
        else $error("hit result flagged degenerate");

endmodule

bind grid_ray_trace_to_wall_core grtw_checker u_checker (.*);

`default_nettype wire
